// ===== hdl/shc_pkg.sv =====
// ----------------------------------------------------------------------------
// shc_pkg
// Shared constants for the size hint constrain block.
// ----------------------------------------------------------------------------
package shc_pkg;

    // Width of one pixel dimension in the register and stream fields
    localparam int DIM_W = 16;

    // Defaults for the top level parameters
    localparam int DIM_BITS_DEF    = 16;
    localparam int FLOOR_UNITS_DEF = 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_HINTS_VALID  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_SIZE     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ASPECT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ASPECT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_PIXELS = 4'd7;

endpackage

// ===== hdl/size_hint_constrain.sv =====
// ----------------------------------------------------------------------------
// size_hint_constrain
// Fits a requested window size to window size hints.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one word per request, in order. Most
// of the pipeline lies in the bit-serial divider pipelines: the grid snap,
// which runs for both dimensions side by side, and the two aspect divides.
// The whole pipeline stalls together while a result waits at the output and
// the sink is not ready. Configuration is meant to be written while no
// request is in flight.
module size_hint_constrain #(
    parameter int DIM_BITS    = shc_pkg::DIM_BITS_DEF,
    parameter int FLOOR_UNITS = shc_pkg::FLOOR_UNITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request: [15:0] req_width, [31:16] req_height
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    // result: [15:0] out_width, [31:16] out_height
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0]                   cfg_data
);

    localparam int DW = shc_pkg::DIM_W;
    localparam int VW = $clog2((FLOOR_UNITS + 1) * (1 << DW));
    localparam int PW = VW + DW;
    localparam logic [DW-1:0] LIM = (DIM_BITS < DW) ? DW'((1 << DIM_BITS) - 1) : '1;

    // Configuration registers
    logic          hints_valid_reg;
    logic [31:0]   base_reg, min_reg, max_reg, inc_reg, min_asp_reg, max_asp_reg;
    logic [DW-1:0] floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hints_valid_reg <= 1'b0;
            base_reg        <= '0;
            min_reg         <= '0;
            max_reg         <= '0;
            inc_reg         <= '0;
            min_asp_reg     <= '0;
            max_asp_reg     <= '0;
            floor_reg       <= DW'(1);
        end else if (cfg_valid) begin
            case (cfg_addr)
                shc_pkg::CFG_HINTS_VALID:  hints_valid_reg <= cfg_data[0];
                shc_pkg::CFG_BASE_SIZE:    base_reg        <= cfg_data;
                shc_pkg::CFG_MIN_SIZE:     min_reg         <= cfg_data;
                shc_pkg::CFG_MAX_SIZE:     max_reg         <= cfg_data;
                shc_pkg::CFG_INC_SIZE:     inc_reg         <= cfg_data;
                shc_pkg::CFG_MIN_ASPECT:   min_asp_reg     <= cfg_data;
                shc_pkg::CFG_MAX_ASPECT:   max_asp_reg     <= cfg_data;
                shc_pkg::CFG_FLOOR_PIXELS: floor_reg       <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: everything moves unless the output word is held
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Per-dimension front end
    logic          w_vld, h_vld;
    logic [VW-1:0] w_v, h_v;

    shc_dim #(.FLOOR_UNITS(FLOOR_UNITS), .VW(VW)) u_dim_w (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .v_in        (s_tdata[15:0]),
        .hints_valid (hints_valid_reg),
        .base_px     (base_reg[15:0]),
        .min_px      (min_reg[15:0]),
        .max_px      (max_reg[15:0]),
        .inc_px      (inc_reg[15:0]),
        .floor_px    (floor_reg),
        .out_valid   (w_vld),
        .v_out       (w_v)
    );

    shc_dim #(.FLOOR_UNITS(FLOOR_UNITS), .VW(VW)) u_dim_h (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .v_in        (s_tdata[31:16]),
        .hints_valid (hints_valid_reg),
        .base_px     (base_reg[31:16]),
        .min_px      (min_reg[31:16]),
        .max_px      (max_reg[31:16]),
        .inc_px      (inc_reg[31:16]),
        .floor_px    (floor_reg),
        .out_valid   (h_vld),
        .v_out       (h_v)
    );

    logic [DW-1:0] num1, den1, num2, den2;
    assign num1 = min_asp_reg[31:16];
    assign den1 = min_asp_reg[15:0];
    assign num2 = max_asp_reg[31:16];
    assign den2 = max_asp_reg[15:0];

    // A1: cross products
    logic          a1_vld_reg;
    logic [PW-1:0] a1_pw1_reg, a1_ph1_reg, a1_pw2_reg;
    logic [VW-1:0] a1_w_reg, a1_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_vld_reg <= 1'b0;
        end else if (en) begin
            a1_vld_reg <= w_vld && h_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_pw1_reg <= PW'(w_v) * PW'(den1);
            a1_ph1_reg <= PW'(num1) * PW'(h_v);
            a1_pw2_reg <= PW'(w_v) * PW'(den2);
            a1_w_reg   <= w_v;
            a1_h_reg   <= h_v;
        end
    end

    // A2: minimum aspect test
    logic          a2_vld_reg, a2_c1_reg;
    logic [PW-1:0] a2_pw1_reg, a2_pw2_reg;
    logic [VW-1:0] a2_w_reg, a2_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a2_vld_reg <= 1'b0;
        end else if (en) begin
            a2_vld_reg <= a1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_c1_reg  <= hints_valid_reg && num1 != '0 && den1 != '0
                          && (a1_pw1_reg < a1_ph1_reg);
            a2_pw1_reg <= a1_pw1_reg;
            a2_pw2_reg <= a1_pw2_reg;
            a2_w_reg   <= a1_w_reg;
            a2_h_reg   <= a1_h_reg;
        end
    end

    // First aspect divide
    logic          d1_vld, d1_c1;
    logic [PW-1:0] d1_q, d1_pw2;
    logic [VW-1:0] d1_w, d1_h;

    shc_div #(.NW(PW), .DW(DW), .SW(1 + 2*VW + PW)) u_div_min (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a2_vld_reg),
        .dividend  (a2_pw1_reg),
        .divisor   (num1),
        .in_side   ({a2_c1_reg, a2_w_reg, a2_h_reg, a2_pw2_reg}),
        .out_valid (d1_vld),
        .quotient  (d1_q),
        .out_side  ({d1_c1, d1_w, d1_h, d1_pw2})
    );

    // A3: height after minimum aspect (quotient is below h when taken)
    logic          a3_vld_reg;
    logic [VW-1:0] a3_w_reg, a3_h_reg;
    logic [PW-1:0] a3_pw2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a3_vld_reg <= 1'b0;
        end else if (en) begin
            a3_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_h_reg   <= d1_c1 ? d1_q[VW-1:0] : d1_h;
            a3_w_reg   <= d1_w;
            a3_pw2_reg <= d1_pw2;
        end
    end

    // A4: num * h for maximum aspect
    logic          a4_vld_reg;
    logic [VW-1:0] a4_w_reg, a4_h_reg;
    logic [PW-1:0] a4_pw2_reg, a4_ph2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a4_vld_reg <= 1'b0;
        end else if (en) begin
            a4_vld_reg <= a3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a4_ph2_reg <= PW'(num2) * PW'(a3_h_reg);
            a4_w_reg   <= a3_w_reg;
            a4_h_reg   <= a3_h_reg;
            a4_pw2_reg <= a3_pw2_reg;
        end
    end

    // A5: maximum aspect test
    logic          a5_vld_reg, a5_c2_reg;
    logic [VW-1:0] a5_w_reg, a5_h_reg;
    logic [PW-1:0] a5_pw2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a5_vld_reg <= 1'b0;
        end else if (en) begin
            a5_vld_reg <= a4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a5_c2_reg  <= hints_valid_reg && num2 != '0 && den2 != '0
                          && (a4_pw2_reg > a4_ph2_reg);
            a5_w_reg   <= a4_w_reg;
            a5_h_reg   <= a4_h_reg;
            a5_pw2_reg <= a4_pw2_reg;
        end
    end

    // Second aspect divide
    logic          d2_vld, d2_c2;
    logic [PW-1:0] d2_q;
    logic [VW-1:0] d2_w, d2_h;

    shc_div #(.NW(PW), .DW(DW), .SW(1 + 2*VW)) u_div_max (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a5_vld_reg),
        .dividend  (a5_pw2_reg),
        .divisor   (num2),
        .in_side   ({a5_c2_reg, a5_w_reg, a5_h_reg}),
        .out_valid (d2_vld),
        .quotient  (d2_q),
        .out_side  ({d2_c2, d2_w, d2_h})
    );

    // Output register with saturation
    logic [PW-1:0] h_full_next;
    logic [DW-1:0] w_sat_next, h_sat_next;
    logic [31:0]   m_tdata_reg;

    always_comb begin
        h_full_next = d2_c2 ? d2_q : PW'(d2_h);
        w_sat_next  = (d2_w > VW'(LIM)) ? LIM : d2_w[DW-1:0];
        h_sat_next  = (h_full_next > PW'(LIM)) ? LIM : h_full_next[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) m_tdata_reg <= {h_sat_next, w_sat_next};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // reset empties the output
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // results never exceed the saturation limit
    a_sat_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= LIM && m_tdata[31:16] <= LIM))
        else $error("result above saturation limit");

    // width and height lanes stay in lock step
    a_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        w_vld == h_vld)
        else $error("dimension pipelines out of step");
`endif

endmodule

// ===== hdl/shc_div.sv =====
// ----------------------------------------------------------------------------
// shc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module shc_div #(
    parameter int NW = 17,
    parameter int DW = shc_pkg::DIM_W,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] quotient,
    output logic [SW-1:0] out_side
);

    // Register k holds the state after bit step k-1
    logic          vld_reg  [1:NW];
    logic [NW-1:0] dq_reg   [1:NW];
    logic [DW-1:0] rem_reg  [1:NW];
    logic [DW-1:0] dvs_reg  [1:NW];
    logic [SW-1:0] side_reg [1:NW];

    // Inputs and results of each bit step
    logic [NW-1:0] dq_in      [NW];
    logic [DW-1:0] rem_in     [NW];
    logic [DW-1:0] dvs_in     [NW];
    logic [DW:0]   trial_next [NW];
    logic [DW:0]   diff_next  [NW];
    logic          take_next  [NW];

    // shift in next dividend bit, subtract when it fits
    always_comb begin
        dq_in[0]  = dividend;
        rem_in[0] = '0;
        dvs_in[0] = divisor;
        for (int k = 1; k < NW; k++) begin
            dq_in[k]  = dq_reg[k];
            rem_in[k] = rem_reg[k];
            dvs_in[k] = dvs_reg[k];
        end
        for (int k = 0; k < NW; k++) begin
            trial_next[k] = {rem_in[k], dq_in[k][NW-1]};
            diff_next[k]  = trial_next[k] - {1'b0, dvs_in[k]};
            take_next[k]  = (trial_next[k] >= {1'b0, dvs_in[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= NW; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= NW; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= in_side;
            for (int k = 2; k <= NW; k++) side_reg[k] <= side_reg[k-1];
            for (int k = 1; k <= NW; k++) begin
                rem_reg[k] <= take_next[k-1] ? diff_next[k-1][DW-1:0]
                                             : trial_next[k-1][DW-1:0];
                dq_reg[k]  <= {dq_in[k-1][NW-2:0], take_next[k-1]};
                dvs_reg[k] <= dvs_in[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NW];
    assign quotient  = dq_reg[NW];
    assign out_side  = side_reg[NW];

`ifndef SYNTHESIS
    // remainder left at the end is always below a nonzero divisor
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NW] && dvs_reg[NW] != '0) |-> (rem_reg[NW] < dvs_reg[NW]))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hdl/shc_dim.sv =====
// ----------------------------------------------------------------------------
// shc_dim
// One dimension: floor, min/max clamp, grid snap and second min clamp.
// ----------------------------------------------------------------------------
module shc_dim #(
    parameter int FLOOR_UNITS = shc_pkg::FLOOR_UNITS_DEF,
    parameter int VW          = 17
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [shc_pkg::DIM_W-1:0] v_in,
    input  logic                      hints_valid,
    input  logic [shc_pkg::DIM_W-1:0] base_px,
    input  logic [shc_pkg::DIM_W-1:0] min_px,
    input  logic [shc_pkg::DIM_W-1:0] max_px,
    input  logic [shc_pkg::DIM_W-1:0] inc_px,
    input  logic [shc_pkg::DIM_W-1:0] floor_px,
    output logic                      out_valid,
    output logic [VW-1:0]             v_out
);

    localparam int DW = shc_pkg::DIM_W;
    localparam int PW = VW + DW;

    logic          use_grid;
    logic [VW-1:0] base_x, min_x, max_x;

    assign use_grid = hints_valid && (inc_px > DW'(1));
    assign base_x   = VW'(base_px);
    assign min_x    = VW'(min_px);
    assign max_x    = VW'(max_px);

    // Stage 1: floor
    logic [VW-1:0] fl_next, s1_v_next, s1_v_reg;
    logic          s1_vld_reg;

    always_comb begin
        fl_next   = use_grid ? VW'(base_x + VW'(FLOOR_UNITS) * VW'(inc_px))
                             : VW'(floor_px);
        s1_v_next = (VW'(v_in) < fl_next) ? fl_next : VW'(v_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) s1_v_reg <= s1_v_next;
    end

    // Stage 2: min/max clamp, grid origin and offset
    logic [VW-1:0] c1_next, c2_next, g_next, over_next;
    logic [VW-1:0] s2_v_reg, s2_g_reg, s2_over_reg;
    logic          s2_vld_reg;

    always_comb begin
        c1_next = (min_x != '0 && s1_v_reg < min_x) ? min_x : s1_v_reg;
        c2_next = (max_x != '0 && c1_next > max_x) ? max_x : c1_next;
        if (!hints_valid) c2_next = s1_v_reg;
        g_next    = (base_x != '0) ? base_x : min_x;
        over_next = (c2_next > g_next) ? (c2_next - g_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_v_reg    <= c2_next;
            s2_g_reg    <= g_next;
            s2_over_reg <= over_next;
        end
    end

    // Offset over increment
    logic          dv_vld;
    logic [VW-1:0] dv_q;
    logic [VW-1:0] dv_g, dv_v;

    shc_div #(.NW(VW), .DW(DW), .SW(2*VW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .dividend  (s2_over_reg),
        .divisor   (inc_px),
        .in_side   ({s2_g_reg, s2_v_reg}),
        .out_valid (dv_vld),
        .quotient  (dv_q),
        .out_side  ({dv_g, dv_v})
    );

    // Stage 3: quotient times increment
    logic [PW-1:0] s3_p_reg;
    logic [VW-1:0] s3_g_reg, s3_v_reg;
    logic          s3_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_p_reg <= PW'(dv_q) * PW'(inc_px);
            s3_g_reg <= dv_g;
            s3_v_reg <= dv_v;
        end
    end

    // Stage 4: snapped value and second min clamp
    logic [VW-1:0] snap_next, s4_next, s4_v_reg;
    logic          s4_vld_reg;

    always_comb begin
        snap_next = use_grid ? VW'(s3_g_reg + s3_p_reg[VW-1:0]) : s3_v_reg;
        s4_next   = (hints_valid && min_x != '0 && snap_next < min_x) ? min_x : snap_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) s4_v_reg <= s4_next;
    end

    assign out_valid = s4_vld_reg;
    assign v_out     = s4_v_reg;

endmodule

// ===== sim/size_hint_constrain_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_hint_constrain_test
// Self-checking bench for the size hint constrain block: configures the hints
// over several settings, streams directed and random size requests with
// random idling on both sides, and compares every result word with a local
// model of the floor, clamp, grid snap and aspect steps.
// ----------------------------------------------------------------------------
module size_hint_constrain_test;

    localparam int LATENCY   = 17 + 2*(17+16) + 10;
    localparam int STALL_MAX = 20000;

    // ------------------------------------------------------------------------
    // Size predictor and queue of pending results
    // ------------------------------------------------------------------------
    class size_scoreboard;
        bit        valid_hints;
        bit [31:0] base_r, min_r, max_r, inc_r, amin_r, amax_r;
        bit [15:0] floor_r;
        bit [31:0] pending_sizes[$];
        int        mismatches;

        function void clear_regs();
            valid_hints = 0;
            base_r = 0; min_r = 0; max_r = 0; inc_r = 0; amin_r = 0; amax_r = 0;
            floor_r = 1;
        endfunction

        function void write_reg(bit [shc_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
            case (idx)
                shc_pkg::CFG_HINTS_VALID:  valid_hints = val[0];
                shc_pkg::CFG_BASE_SIZE:    base_r = val;
                shc_pkg::CFG_MIN_SIZE:     min_r = val;
                shc_pkg::CFG_MAX_SIZE:     max_r = val;
                shc_pkg::CFG_INC_SIZE:     inc_r = val;
                shc_pkg::CFG_MIN_ASPECT:   amin_r = val;
                shc_pkg::CFG_MAX_ASPECT:   amax_r = val;
                shc_pkg::CFG_FLOOR_PIXELS: floor_r = val[15:0];
                default: ;
            endcase
        endfunction

        // one dimension: floor, min/max clamp, grid snap, min again
        function longint unsigned fit(longint unsigned v, longint unsigned b,
                                      longint unsigned mn, longint unsigned mx,
                                      longint unsigned inc);
            longint unsigned fl, g, over;
            if (valid_hints && inc > 1) begin
                fl = b + shc_pkg::FLOOR_UNITS_DEF * inc;
                if (v < fl) v = fl;
            end else if (v < floor_r) begin
                v = floor_r;
            end
            if (!valid_hints) return v;
            if (mn > 0 && v < mn) v = mn;
            if (mx > 0 && v > mx) v = mx;
            if (inc > 1) begin
                g = (b > 0) ? b : mn;
                over = (v > g) ? v - g : 0;
                v = g + (over / inc) * inc;
            end
            if (mn > 0 && v < mn) v = mn;
            return v;
        endfunction

        function void note_request(bit [31:0] req);
            longint unsigned w, h, num, den;
            bit [15:0] ow, oh;
            w = fit(req[15:0], base_r[15:0], min_r[15:0], max_r[15:0], inc_r[15:0]);
            h = fit(req[31:16], base_r[31:16], min_r[31:16], max_r[31:16],
                    inc_r[31:16]);
            if (valid_hints) begin
                num = amin_r[31:16]; den = amin_r[15:0];
                if (num > 0 && den > 0 && w*den < num*h) h = (w*den) / num;
                num = amax_r[31:16]; den = amax_r[15:0];
                if (num > 0 && den > 0 && w*den > num*h) h = (w*den) / num;
            end
            ow = (w > 65535) ? 16'hFFFF : w[15:0];
            oh = (h > 65535) ? 16'hFFFF : h[15:0];
            pending_sizes.push_back({oh, ow});
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(bit [31:0] got);
            bit [31:0] exp;
            if (pending_sizes.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            exp = pending_sizes.pop_front();
            if (got[15:0] != exp[15:0])
                report($sformatf("out_width %0d, expected %0d", got[15:0], exp[15:0]));
            if (got[31:16] != exp[31:16])
                report($sformatf("out_height %0d, expected %0d",
                                 got[31:16], exp[31:16]));
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
    logic s_tready, m_tvalid, cfg_ready;
    logic [31:0] s_tdata = 0, m_tdata, cfg_data = 0;
    logic [shc_pkg::CFG_IDX_W-1:0] cfg_addr = '0;

    size_scoreboard sb = new();
    int  idle_pct = 29;
    int  quiet_cycles = 0;

    always #6 aclk = ~aclk;

    size_hint_constrain u_top (.*);

    // sink side: random stall, check on accept
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_cfg(bit [shc_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
        s_tvalid <= 0;
        cfg_valid <= 1; cfg_addr <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic send_request(bit [15:0] w, bit [15:0] h);
        cfg_valid <= 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1; s_tdata <= {h, w};
        do @(posedge aclk); while (!s_tready);
        sb.note_request({h, w});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        cfg_valid <= 0;
        while (sb.pending_sizes.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // mostly small dimensions, sometimes full range
    function automatic bit [15:0] rand_dim();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(15));
            default: return 16'($urandom_range(2000));
        endcase
    endfunction

    function automatic bit [31:0] rand_pair(int lim);
        return {16'($urandom_range(lim)), 16'($urandom_range(lim))};
    endfunction

    task automatic random_config(int phase);
        int lim;
        lim = (phase % 3 == 0) ? 65535 : 300;
        write_cfg(shc_pkg::CFG_HINTS_VALID, 32'(phase % 5 != 4));
        write_cfg(shc_pkg::CFG_BASE_SIZE, ($urandom_range(2) == 0) ? 0 : rand_pair(lim));
        write_cfg(shc_pkg::CFG_MIN_SIZE, ($urandom_range(2) == 0) ? 0 : rand_pair(lim));
        write_cfg(shc_pkg::CFG_MAX_SIZE, ($urandom_range(2) == 0) ? 0 : rand_pair(65535));
        write_cfg(shc_pkg::CFG_INC_SIZE, ($urandom_range(3) == 0) ? 0 : rand_pair(
                  ($urandom_range(1) == 0) ? 20 : 65535));
        write_cfg(shc_pkg::CFG_MIN_ASPECT, ($urandom_range(2) == 0) ? 0 : rand_pair(
                  ($urandom_range(1) == 0) ? 16 : 65535));
        write_cfg(shc_pkg::CFG_MAX_ASPECT, ($urandom_range(2) == 0) ? 0 : rand_pair(
                  ($urandom_range(1) == 0) ? 16 : 65535));
        write_cfg(shc_pkg::CFG_FLOOR_PIXELS,
                  ($urandom_range(4) == 0) ? 0 : $urandom_range(65535));
    endtask

    initial begin
        sb.clear_regs();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings, extremes
        send_request(0, 0);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h5555, 16'hAAAA);
        drain();
        // hints with grid, min above max, aspect ranges
        write_cfg(shc_pkg::CFG_HINTS_VALID, 1);
        write_cfg(shc_pkg::CFG_BASE_SIZE, {16'd10, 16'd20});
        write_cfg(shc_pkg::CFG_MIN_SIZE, {16'd500, 16'd40});
        write_cfg(shc_pkg::CFG_MAX_SIZE, {16'd300, 16'd1000});
        write_cfg(shc_pkg::CFG_INC_SIZE, {16'd7, 16'd9});
        write_cfg(shc_pkg::CFG_MIN_ASPECT, {16'd3, 16'd4});
        write_cfg(shc_pkg::CFG_MAX_ASPECT, {16'd2, 16'd1});
        write_cfg(shc_pkg::CFG_FLOOR_PIXELS, 0);
        send_request(0, 0);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(555, 123);
        send_request(1, 65535);
        drain();
        // saturation: huge base plus increment
        write_cfg(shc_pkg::CFG_BASE_SIZE, 32'hFFFF_FFFF);
        write_cfg(shc_pkg::CFG_INC_SIZE, 32'hFFFF_FFFF);
        write_cfg(shc_pkg::CFG_MIN_SIZE, 0);
        write_cfg(shc_pkg::CFG_MAX_SIZE, 0);
        write_cfg(shc_pkg::CFG_MIN_ASPECT, 32'hFFFF_0001);
        write_cfg(shc_pkg::CFG_MAX_ASPECT, 32'h0001_FFFF);
        send_request(0, 0);
        send_request(16'hFFFF, 1);
        drain();
        write_cfg(shc_pkg::CFG_BASE_SIZE, 0);
        write_cfg(shc_pkg::CFG_MIN_SIZE, {16'd30, 16'd30});
        write_cfg(shc_pkg::CFG_INC_SIZE, {16'd1, 16'd2});
        write_cfg(shc_pkg::CFG_FLOOR_PIXELS, 16'hFFFF);
        send_request(5, 5);
        send_request(16'hFFFF, 0);
        drain();

        // random phases; one phase without idling
        for (int phase = 0; phase < 16; phase++) begin
            random_config(phase);
            idle_pct = (phase == 7) ? 0 : 29;
            repeat (103) send_request(rand_dim(), rand_dim());
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_sizes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
